// ===== src/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants for the frustum point culling block
// Command codes, the queued item layout, plane constants and widths.
// ----------------------------------------------------------------------------
package fpc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int VALUE_W       = 32;
   localparam int COEF_W        = VALUE_W + 1;
   localparam int PROD_W        = COEF_W + VALUE_W;
   // Three products of at most 2^63 plus a scaled offset fit in 68 signed bits.
   localparam int ACC_W         = PROD_W + 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [2:0] PLANE_LAST = 3'd5;
   localparam logic [2:0] PLANE_NONE = 3'd6;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TEST = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic [3:0]                  addr;
      logic signed [VALUE_W-1:0]   value;
      logic signed [VALUE_W-1:0]   x;
      logic signed [VALUE_W-1:0]   y;
      logic signed [VALUE_W-1:0]   z;
   } item_type;

   // Left, bottom and back add the plane column to column 3; the others subtract.
   function automatic logic plane_adds(input logic [2:0] plane);
      logic adds;
      case (plane)
         3'd1, 3'd2, 3'd5: adds = 1'b1;
         default:          adds = 1'b0;
      endcase
      return adds;
   endfunction

endpackage

// ===== src/fpc_front.sv =====
// ----------------------------------------------------------------------------
// fpc_front: input stage
// Accepts request beats, decodes the command and forms the store address,
// and hands the packed item to the queue.
// ----------------------------------------------------------------------------
module fpc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [0:0]                    req_cmd,
   input  logic [1:0]                    req_row_index,
   input  logic [1:0]                    req_col_index,
   input  logic signed [31:0]            req_entry_value,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_point_z,
   output logic                          q_push,
   output fpc_pkg::item_type             q_item,
   input  logic                          q_full
);
   import fpc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign q_push = valid_ff && !q_full;
   assign full   = valid_ff && q_full;
   assign accept = push && !full;
   assign q_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in      = 1'b1;
         item_in.cmd   = cmd_type'(req_cmd);
         item_in.addr  = {req_row_index, req_col_index};
         item_in.value = req_entry_value;
         item_in.x     = req_point_x;
         item_in.y     = req_point_y;
         item_in.z     = req_point_z;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== src/fpc_queue.sv =====
// ----------------------------------------------------------------------------
// fpc_queue: short item queue
// Decouples the input stage from the plane evaluator.
// ----------------------------------------------------------------------------
module fpc_queue #(
   parameter int DEPTH = fpc_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fpc_pkg::item_type    push_item,
   output logic                 full,
   input  logic                 pop,
   output fpc_pkg::item_type    pop_item,
   output logic                 empty
);
   import fpc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/fpc_back.sv =====
// ----------------------------------------------------------------------------
// fpc_back: clip store and plane evaluator
// Executes queued loads into the clip store and tests points plane by plane
// with one shared multiplier, holding each verdict in the result register.
// ----------------------------------------------------------------------------
module fpc_back #(
   parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  fpc_pkg::item_type    q_item,
   output logic                 q_pop,
   input  logic                 pop,
   output logic                 empty,
   output logic                 rsp_inside_res,
   output logic [2:0]           rsp_failing_plane
);
   import fpc_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [VALUE_W-1:0]  clip_ff [16];
   logic signed [VALUE_W-1:0]  pt_ff [3];
   logic signed [VALUE_W-1:0]  pt_in [3];
   logic [2:0]                 plane_ff, plane_in;
   logic [1:0]                 step_ff, step_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       inside_ff, inside_in;
   logic [2:0]                 fail_ff, fail_in;

   logic signed [COEF_W-1:0]   coef_row [4];
   logic signed [COEF_W-1:0]   mul_coef;
   logic signed [VALUE_W-1:0]  mul_pt;
   logic signed [ACC_W-1:0]    offset;
   logic signed [ACC_W-1:0]    plane_sum;
   logic [1:0]                 col_sel;
   logic                       add_sel;
   logic                       fail_now;
   logic                       slot_free;
   logic                       finish;
   logic                       rsp_pop;
   logic                       store_we;

   assign col_sel = plane_ff[2:1];
   assign add_sel = plane_adds(plane_ff);

   // Coefficient of each row for the current plane: column 3 plus or minus the
   // plane's own column.
   for (genvar i = 0; i < 4; i++) begin : g_row
      logic signed [VALUE_W-1:0] pick;
      logic signed [COEF_W-1:0]  w_ext, c_ext;
      always_comb begin
         case (col_sel)
            2'd0:    pick = clip_ff[4*i+0];
            2'd1:    pick = clip_ff[4*i+1];
            default: pick = clip_ff[4*i+2];
         endcase
         w_ext = {clip_ff[4*i+3][VALUE_W-1], clip_ff[4*i+3]};
         c_ext = {pick[VALUE_W-1], pick};
         coef_row[i] = add_sel ? (w_ext + c_ext) : (w_ext - c_ext);
      end
   end

   always_comb begin
      case (step_ff)
         2'd0:    begin mul_coef = coef_row[0]; mul_pt = pt_ff[0]; end
         2'd1:    begin mul_coef = coef_row[1]; mul_pt = pt_ff[1]; end
         default: begin mul_coef = coef_row[2]; mul_pt = pt_ff[2]; end
      endcase
   end

   assign prod_in   = mul_coef * mul_pt;
   assign offset    = $signed({{(ACC_W-COEF_W){coef_row[3][COEF_W-1]}}, coef_row[3]})
                      <<< FRAC_BITS;
   assign plane_sum = acc_ff + ACC_W'(prod_ff);
   assign fail_now  = plane_sum[ACC_W-1] || (plane_sum == '0);

   assign rsp_pop   = pop && rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign finish    = (state_ff == ST_RUN) && (step_ff == 2'd3) &&
                      (fail_now || plane_ff == PLANE_LAST) && slot_free;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign store_we  = q_pop && (q_item.cmd == CMD_LOAD);

   assign empty             = !rsp_valid_ff;
   assign rsp_inside_res    = inside_ff;
   assign rsp_failing_plane = fail_ff;

   always_comb begin
      state_in     = state_ff;
      plane_in     = plane_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      pt_in        = pt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      inside_in    = inside_ff;
      fail_in      = fail_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop && q_item.cmd == CMD_TEST) begin
               state_in = ST_RUN;
               plane_in = 3'd0;
               step_in  = 2'd0;
               pt_in[0] = q_item.x;
               pt_in[1] = q_item.y;
               pt_in[2] = q_item.z;
            end
         end
         ST_RUN: begin
            case (step_ff)
               2'd0: begin
                  acc_in  = offset;
                  step_in = 2'd1;
               end
               2'd1, 2'd2: begin
                  acc_in  = plane_sum;
                  step_in = step_ff + 2'd1;
               end
               default: begin
                  if (finish) begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                     inside_in    = !fail_now;
                     fail_in      = fail_now ? plane_ff : PLANE_NONE;
                  end else if (!fail_now && plane_ff != PLANE_LAST) begin
                     plane_in = plane_ff + 3'd1;
                     step_in  = 2'd0;
                  end
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         plane_ff     <= 3'd0;
         step_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         plane_ff     <= plane_in;
         step_ff      <= step_in;
      end
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      pt_ff     <= pt_in;
      inside_ff <= inside_in;
      fail_ff   <= fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) begin
            clip_ff[k] <= '0;
         end
      end else if (store_we) begin
         clip_ff[q_item.addr] <= q_item.value;
      end
   end

   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (plane_ff <= PLANE_LAST))
      else $error("plane counter out of range");

   a_verdict_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (inside_ff == (fail_ff == PLANE_NONE)))
      else $error("inside flag disagrees with failing plane");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (finish && rsp_valid_ff) |-> pop)
      else $error("result written over an unread beat");

   a_load_no_run: assert property (@(posedge clock) disable iff (reset)
      store_we |=> (state_ff == ST_IDLE))
      else $error("load started a plane test");

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff == 2'd0) |=> (step_ff == 2'd1))
      else $error("plane step sequence broken");

endmodule

// ===== src/frustum_point_culling.sv =====
// ----------------------------------------------------------------------------
// frustum_point_culling: view-frustum point test against a loaded clip matrix
// Load beats write one clip matrix entry; test beats return inside/outside and
// the first failing plane.
// ----------------------------------------------------------------------------
// A load passes the input stage register and a queue slot before it is written
// to the clip store; a test takes the same path, then the plane steps on the
// shared multiplier, stopping at the first failing plane. One load is taken
// per cycle while the input stage is not full; a queued test waits until the
// plane sequencer is idle. Reset is synchronous: it empties the queue and
// result register and clears the whole clip store to zero.
module frustum_point_culling #(
   parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [0:0]          req_cmd,
   input  logic [1:0]          req_row_index,
   input  logic [1:0]          req_col_index,
   input  logic signed [31:0]  req_entry_value,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   output logic                empty,
   input  logic                pop,
   output logic                rsp_inside_res,
   output logic [2:0]          rsp_failing_plane
);
   import fpc_pkg::*;

   logic     f_push, f_full;
   item_type f_item;
   logic     b_pop, b_empty;
   item_type b_item;

   fpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_cmd         (req_cmd),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_entry_value (req_entry_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .q_push          (f_push),
      .q_item          (f_item),
      .q_full          (f_full)
   );

   fpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .full      (f_full),
      .pop       (b_pop),
      .pop_item  (b_item),
      .empty     (b_empty)
   );

   fpc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (b_empty),
      .q_item            (b_item),
      .q_pop             (b_pop),
      .pop               (pop),
      .empty             (empty),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_failing_plane (rsp_failing_plane)
   );

endmodule
